>>> rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler: the
// request command codes, fixed field widths, controller states and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

   // Fixed widths of the item fields on the ports
   localparam int JOB_W      = 4;
   localparam int PRI_PORT_W = 8;
   localparam int TIME_PORT_W = 16;
   localparam int TURN_W     = 16;

   // Request command codes
   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_SCAN,
      ST_EXEC
   } pps_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;       // capture the request fields
      logic scan_clear;  // restart the table scan
      logic scan_step;   // read / compare one table entry
      logic arrive;      // insert the captured job, emit result
      logic exec;        // dispatch, run one tick, emit result
   } pps_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;   // last entry compared this cycle
   } pps_stat_type;

endpackage

>>> rtl/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Scheduler controller: accepts an item, then sequences either the table
// insert or the table scan followed by the dispatch / execute step.
// ----------------------------------------------------------------------------
module pps_ctrl
   import pps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_cmd,
   input  pps_stat_type stat,
   output pps_cmd_type  cmd,
   output logic         busy
);

   pps_state_type state_ff;
   pps_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_cmd == CMD_ARRIVE) ? ST_ARRIVE : ST_SCAN;
            end
         end
         ST_ARRIVE: state_in = ST_IDLE;
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy           = 1'b0;
            cmd.latch      = start;
            cmd.scan_clear = start;
         end
         ST_ARRIVE: cmd.arrive    = 1'b1;
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_EXEC:   cmd.exec      = 1'b1;
         default:   busy          = 1'b1;
      endcase
   end

endmodule

>>> rtl/pps_dpath.sv
// ----------------------------------------------------------------------------
// pps_dpath
// Scheduler datapath: waiting job table (RAM plus valid bits), sequential
// best-job scan, server registers, tick counter and the result register.
// ----------------------------------------------------------------------------
module pps_dpath
   import pps_pkg::*;
#(
   parameter int MAX_JOBS      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TIME_BITS     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pps_cmd_type            cmd,
   output pps_stat_type           stat,
   input  logic [JOB_W-1:0]       req_job_id,
   input  logic [PRI_PORT_W-1:0]  req_priority_req,
   input  logic [TIME_PORT_W-1:0] req_run_time,
   output logic                   rsp_valid,
   output logic                   rsp_rejected,
   output logic                   rsp_busy_res,
   output logic [JOB_W-1:0]       rsp_running_job,
   output logic                   rsp_dispatched,
   output logic                   rsp_completed,
   output logic [TURN_W-1:0]      rsp_turnaround
);

   localparam int IDX_W  = $clog2(MAX_JOBS);
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int WORD_W = JOB_W + PRIORITY_BITS + 2 * TIME_BITS;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_JOBS);
   localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

   // Captured request
   logic [JOB_W-1:0]         req_job_ff, req_job_in;
   logic [PRIORITY_BITS-1:0] req_pri_ff, req_pri_in;
   logic [TIME_BITS-1:0]     req_time_ff, req_time_in;

   // Table valid bits
   logic [MAX_JOBS-1:0] valid_ff, valid_in;

   // Scan state
   logic [CNT_W-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                     cmp_live_ff, cmp_live_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     have_best_ff, have_best_in;
   logic [IDX_W-1:0]         best_slot_ff, best_slot_in;
   logic [JOB_W-1:0]         best_job_ff, best_job_in;
   logic [PRIORITY_BITS-1:0] best_pri_ff, best_pri_in;
   logic [TIME_BITS-1:0]     best_rem_ff, best_rem_in;
   logic [TIME_BITS-1:0]     best_arr_ff, best_arr_in;

   // Server and time
   logic                     run_active_ff, run_active_in;
   logic [JOB_W-1:0]         run_job_ff, run_job_in;
   logic [PRIORITY_BITS-1:0] run_pri_ff, run_pri_in;
   logic [TIME_BITS-1:0]     run_rem_ff, run_rem_in;
   logic [TIME_BITS-1:0]     run_arr_ff, run_arr_in;
   logic [TIME_BITS-1:0]     tick_ff, tick_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_rejected_ff, rsp_rejected_in;
   logic              rsp_busy_ff, rsp_busy_in;
   logic [JOB_W-1:0]  rsp_job_ff, rsp_job_in;
   logic              rsp_disp_ff, rsp_disp_in;
   logic              rsp_comp_ff, rsp_comp_in;
   logic [TURN_W-1:0] rsp_turn_ff, rsp_turn_in;

   // RAM port signals
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   logic [JOB_W-1:0]         rd_job;
   logic [PRIORITY_BITS-1:0] rd_pri;
   logic [TIME_BITS-1:0]     rd_rem;
   logic [TIME_BITS-1:0]     rd_arr;

   logic             table_full;
   logic [IDX_W-1:0] free_idx;
   logic             better;

   logic                     swap, take, disp, eff_active, done_now;
   logic [JOB_W-1:0]         eff_job;
   logic [PRIORITY_BITS-1:0] eff_pri;
   logic [TIME_BITS-1:0]     eff_rem, eff_arr, turn_full;

   pps_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_JOBS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Unpack the table word: {job, priority, remaining, arrival}
   assign rd_arr = ram_rdata[TIME_BITS-1:0];
   assign rd_rem = ram_rdata[2*TIME_BITS-1:TIME_BITS];
   assign rd_pri = ram_rdata[2*TIME_BITS+PRIORITY_BITS-1:2*TIME_BITS];
   assign rd_job = ram_rdata[WORD_W-1:2*TIME_BITS+PRIORITY_BITS];

   // Find the lowest free slot
   always_comb begin
      free_idx   = '0;
      table_full = 1'b1;
      for (int i = MAX_JOBS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx   = IDX_W'(i);
            table_full = 1'b0;
         end
      end
   end

   // Compare the entry read last cycle against the best so far
   assign ram_raddr = scan_cnt_ff[IDX_W-1:0];
   assign better = valid_ff[cmp_idx_ff] &&
                   (!have_best_ff || (rd_pri > best_pri_ff) ||
                    ((rd_pri == best_pri_ff) && (rd_job > best_job_ff)));
   assign stat.scan_done = (scan_cnt_ff == CNT_END);

   // Dispatch decision and one tick of execution
   assign take       = !run_active_ff && have_best_ff;
   assign swap       = run_active_ff && have_best_ff && (best_pri_ff > run_pri_ff);
   assign disp       = take || swap;
   assign eff_active = run_active_ff || have_best_ff;
   assign eff_job    = disp ? best_job_ff : run_job_ff;
   assign eff_pri    = disp ? best_pri_ff : run_pri_ff;
   assign eff_rem    = disp ? best_rem_ff : run_rem_ff;
   assign eff_arr    = disp ? best_arr_ff : run_arr_ff;
   assign done_now   = (eff_rem <= TIME_ONE);
   assign turn_full  = tick_ff + TIME_ONE - eff_arr;

   // Table write: new arrival, or the preempted job into the freed slot
   always_comb begin
      ram_we    = (cmd.arrive && !table_full) || (cmd.exec && swap);
      ram_waddr = cmd.arrive ? free_idx : best_slot_ff;
      if (cmd.arrive) begin
         ram_wdata = {req_job_ff, req_pri_ff, req_time_ff, tick_ff};
      end else begin
         ram_wdata = {run_job_ff, run_pri_ff, run_rem_ff, run_arr_ff};
      end
   end

   // Next values of the control registers
   always_comb begin
      valid_in      = valid_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_live_in   = cmp_live_ff;
      have_best_in  = have_best_ff;
      run_active_in = run_active_ff;
      tick_in       = tick_ff;
      rsp_valid_in  = cmd.arrive || cmd.exec;
      if (cmd.scan_clear) begin
         scan_cnt_in  = '0;
         cmp_live_in  = 1'b0;
         have_best_in = 1'b0;
      end
      if (cmd.scan_step) begin
         if (cmp_live_ff && better) begin
            have_best_in = 1'b1;
         end
         if (scan_cnt_ff != CNT_END) begin
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            cmp_live_in = 1'b1;
         end else begin
            cmp_live_in = 1'b0;
         end
      end
      if (cmd.arrive && !table_full) begin
         valid_in[free_idx] = 1'b1;
      end
      if (cmd.exec) begin
         if (take) begin
            valid_in[best_slot_ff] = 1'b0;
         end
         run_active_in = eff_active && !done_now;
         tick_in       = tick_ff + TIME_ONE;
      end
   end

   // Next values of the payload registers
   always_comb begin
      req_job_in   = req_job_ff;
      req_pri_in   = req_pri_ff;
      req_time_in  = req_time_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_slot_in = best_slot_ff;
      best_job_in  = best_job_ff;
      best_pri_in  = best_pri_ff;
      best_rem_in  = best_rem_ff;
      best_arr_in  = best_arr_ff;
      run_job_in   = run_job_ff;
      run_pri_in   = run_pri_ff;
      run_rem_in   = run_rem_ff;
      run_arr_in   = run_arr_ff;
      if (cmd.latch) begin
         req_job_in  = req_job_id;
         req_pri_in  = PRIORITY_BITS'(req_priority_req);
         req_time_in = TIME_BITS'(req_run_time);
      end
      if (cmd.scan_step) begin
         cmp_idx_in = ram_raddr;
         if (cmp_live_ff && better) begin
            best_slot_in = cmp_idx_ff;
            best_job_in  = rd_job;
            best_pri_in  = rd_pri;
            best_rem_in  = rd_rem;
            best_arr_in  = rd_arr;
         end
      end
      if (cmd.exec) begin
         run_job_in = eff_job;
         run_pri_in = eff_pri;
         run_arr_in = eff_arr;
         if (eff_active) begin
            run_rem_in = done_now ? '0 : (eff_rem - TIME_ONE);
         end
      end
   end

   // Build the result
   always_comb begin
      rsp_rejected_in = 1'b0;
      rsp_busy_in     = 1'b0;
      rsp_job_in      = '0;
      rsp_disp_in     = 1'b0;
      rsp_comp_in     = 1'b0;
      rsp_turn_in     = '0;
      if (cmd.arrive) begin
         rsp_rejected_in = table_full;
      end
      if (cmd.exec) begin
         rsp_busy_in = eff_active;
         rsp_disp_in = disp;
         if (eff_active) begin
            rsp_job_in = eff_job;
            if (done_now) begin
               rsp_comp_in = 1'b1;
               rsp_turn_in = TURN_W'(turn_full);
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         scan_cnt_ff   <= '0;
         cmp_live_ff   <= 1'b0;
         have_best_ff  <= 1'b0;
         run_active_ff <= 1'b0;
         tick_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         scan_cnt_ff   <= scan_cnt_in;
         cmp_live_ff   <= cmp_live_in;
         have_best_ff  <= have_best_in;
         run_active_ff <= run_active_in;
         tick_ff       <= tick_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Server payload registers, cleared with the server
   always_ff @(posedge clock) begin
      if (reset) begin
         run_job_ff <= '0;
         run_pri_ff <= '0;
         run_rem_ff <= '0;
         run_arr_ff <= '0;
      end else begin
         run_job_ff <= run_job_in;
         run_pri_ff <= run_pri_in;
         run_rem_ff <= run_rem_in;
         run_arr_ff <= run_arr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_job_ff      <= req_job_in;
      req_pri_ff      <= req_pri_in;
      req_time_ff     <= req_time_in;
      cmp_idx_ff      <= cmp_idx_in;
      best_slot_ff    <= best_slot_in;
      best_job_ff     <= best_job_in;
      best_pri_ff     <= best_pri_in;
      best_rem_ff     <= best_rem_in;
      best_arr_ff     <= best_arr_in;
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_busy_ff     <= rsp_busy_in;
      rsp_job_ff      <= rsp_job_in;
      rsp_disp_ff     <= rsp_disp_in;
      rsp_comp_ff     <= rsp_comp_in;
      rsp_turn_ff     <= rsp_turn_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rejected    = rsp_rejected_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_running_job = rsp_job_ff;
   assign rsp_dispatched  = rsp_disp_ff;
   assign rsp_completed   = rsp_comp_ff;
   assign rsp_turnaround  = rsp_turn_ff;

endmodule

>>> rtl/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Single-server preemptive priority scheduler with a waiting job table.
//
//   Channel   Handshake               Ports
//   request   start & !busy accepts   req_cmd, req_job_id, req_priority_req,
//                                     req_run_time
//   result    rsp_valid, one cycle    rsp_rejected, rsp_busy_res,
//                                     rsp_running_job, rsp_dispatched,
//                                     rsp_completed, rsp_turnaround
//
// An arrival item keeps busy high through the ARRIVE state after acceptance; its result
// strobes in the next cycle, as busy falls.
// A tick item keeps busy high through the SCAN and EXEC states: the job table is
// scanned one entry per cycle through its single read port.
// A result strobes once per item and cannot be held off; the next item may be
// accepted in the cycle the previous result is shown.
// Synchronous reset empties the table, idles the server and clears time.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit
   import pps_pkg::*;
#(
   parameter int MAX_JOBS      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TIME_BITS     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic [JOB_W-1:0]       req_job_id,
   input  logic [PRI_PORT_W-1:0]  req_priority_req,
   input  logic [TIME_PORT_W-1:0] req_run_time,
   output logic                   rsp_valid,
   output logic                   rsp_rejected,
   output logic                   rsp_busy_res,
   output logic [JOB_W-1:0]       rsp_running_job,
   output logic                   rsp_dispatched,
   output logic                   rsp_completed,
   output logic [TURN_W-1:0]      rsp_turnaround
);

   pps_cmd_type  ctrl_cmd;
   pps_stat_type dp_stat;

   pps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_cmd(req_cmd),
      .stat   (dp_stat),
      .cmd    (ctrl_cmd),
      .busy   (busy)
   );

   pps_dpath #(
      .MAX_JOBS     (MAX_JOBS),
      .PRIORITY_BITS(PRIORITY_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .stat            (dp_stat),
      .req_job_id      (req_job_id),
      .req_priority_req(req_priority_req),
      .req_run_time    (req_run_time),
      .rsp_valid       (rsp_valid),
      .rsp_rejected    (rsp_rejected),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_running_job (rsp_running_job),
      .rsp_dispatched  (rsp_dispatched),
      .rsp_completed   (rsp_completed),
      .rsp_turnaround  (rsp_turnaround)
   );

   // An accepted item always starts work
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   // A rejected arrival carries no execution report
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (!rsp_busy_res && !rsp_dispatched))
      else $error("rejected arrival reports execution");

   // Completion only for a job that ran this tick
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_completed) |-> rsp_busy_res)
      else $error("completion without a running job");

   // Turnaround is reported only on completion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_turnaround != '0)) |-> rsp_completed)
      else $error("turnaround without completion");

endmodule
